// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by mrrs_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/mrrs_pkg.sv -----
`timescale 1ns / 1ps
package mrrs_pkg;
   localparam int NUM_TASKS  = 64;
   localparam int NUM_LEVELS = 8;
   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int CNT_W      = $clog2(NUM_TASKS + 1);
   localparam int SLICE_W    = 8;
   localparam int LIST_DEPTH = NUM_LEVELS * NUM_TASKS;
   localparam int LIST_AW    = $clog2(LIST_DEPTH);
   localparam int REQ_W      = 24;
   localparam int RSP_W      = 24;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_SLEEP = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_ALLOC = 2'd1,
      SLOT_RUN   = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      RES_OK      = 2'd0,
      RES_FULL    = 2'd1,
      RES_IGNORED = 2'd2
   } res_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLR,
      OP_LOAD,
      OP_IDX0,
      OP_ALLOC_RD,
      OP_ALLOC_CHK,
      OP_SLOT_RD,
      OP_CAP_SLOT,
      OP_RD_CUR,
      OP_CAP_BEFORE,
      OP_SRCH_INIT,
      OP_SRCH_RD,
      OP_SRCH_CHK,
      OP_REM_UPD,
      OP_SH_RD,
      OP_SH_WR,
      OP_ADD,
      OP_FIND,
      OP_TICK,
      OP_CAP_TOUT,
      OP_RD_SLICE,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type  op;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic     clr_done;
      mode_type mode;
      logic     slot_free;
      logic     alloc_last;
      logic     st_run;
      logic     lvl_change;
      logic     match;
      logic     idx_end;
      logic     is_cur;
      logic     out_free;
   } sts_type;
endpackage

// ----- hw/rtl/mrrs_ram.sv -----
`timescale 1ns / 1ps
module mrrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/mrrs_ctrl.sv -----
`timescale 1ns / 1ps
module mrrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mrrs_pkg::sts_type    sts,
   output mrrs_pkg::cmd_type    cmd
);
   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_ALLOC_RD, S_ALLOC_CHK, S_SLOT_RD, S_SLOT_CAP,
      S_SLOT_DEC, S_BEF_RD, S_BEF_CAP, S_SRCH_INIT, S_SRCH_TEST, S_SRCH_RD,
      S_SRCH_CHK, S_REM_UPD, S_SH_TEST, S_SH_RD, S_SH_WR, S_POST, S_ADD, S_FIND,
      S_TICK, S_TOUT_RD, S_TOUT_CAP, S_SLICE_RD, S_RESULT
   } state_type;

   state_type         state_ff;
   mrrs_pkg::res_type res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         res_ff   <= mrrs_pkg::RES_OK;
      end else begin
         unique case (state_ff)
            S_CLEAR:     if (sts.clr_done) state_ff <= S_IDLE;
            S_IDLE:      if (req_tvalid) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               res_ff <= mrrs_pkg::RES_OK;
               unique case (sts.mode)
                  mrrs_pkg::MODE_ALLOC: state_ff <= S_ALLOC_RD;
                  mrrs_pkg::MODE_TICK:  state_ff <= S_BEF_RD;
                  default:              state_ff <= S_SLOT_RD;
               endcase
            end
            S_ALLOC_RD:  state_ff <= S_ALLOC_CHK;
            S_ALLOC_CHK: begin
               if (sts.slot_free) begin
                  state_ff <= S_RESULT;
               end else if (sts.alloc_last) begin
                  res_ff   <= mrrs_pkg::RES_FULL;
                  state_ff <= S_RESULT;
               end else begin
                  state_ff <= S_ALLOC_RD;
               end
            end
            S_SLOT_RD:   state_ff <= S_SLOT_CAP;
            S_SLOT_CAP:  state_ff <= S_SLOT_DEC;
            S_SLOT_DEC: begin
               if (sts.mode == mrrs_pkg::MODE_RUN) begin
                  if (!sts.st_run) state_ff <= S_ADD;
                  else if (sts.lvl_change) state_ff <= S_SRCH_INIT;
                  else state_ff <= S_TOUT_RD;
               end else if (!sts.st_run) begin
                  res_ff   <= mrrs_pkg::RES_IGNORED;
                  state_ff <= S_TOUT_RD;
               end else begin
                  state_ff <= S_BEF_RD;
               end
            end
            S_BEF_RD:    state_ff <= S_BEF_CAP;
            S_BEF_CAP: begin
               if (sts.mode == mrrs_pkg::MODE_TICK) state_ff <= S_TICK;
               else state_ff <= S_SRCH_INIT;
            end
            S_SRCH_INIT: state_ff <= S_SRCH_TEST;
            S_SRCH_TEST: state_ff <= sts.idx_end ? S_POST : S_SRCH_RD;
            S_SRCH_RD:   state_ff <= S_SRCH_CHK;
            S_SRCH_CHK:  state_ff <= sts.match ? S_REM_UPD : S_SRCH_TEST;
            S_REM_UPD:   state_ff <= S_SH_TEST;
            S_SH_TEST:   state_ff <= sts.idx_end ? S_POST : S_SH_RD;
            S_SH_RD:     state_ff <= S_SH_WR;
            S_SH_WR:     state_ff <= S_SH_TEST;
            S_POST: begin
               if (sts.mode == mrrs_pkg::MODE_RUN) state_ff <= S_ADD;
               else if (sts.is_cur) state_ff <= S_FIND;
               else state_ff <= S_TOUT_RD;
            end
            S_ADD:       state_ff <= S_TOUT_RD;
            S_FIND:      state_ff <= S_TOUT_RD;
            S_TICK:      state_ff <= S_TOUT_RD;
            S_TOUT_RD:   state_ff <= S_TOUT_CAP;
            S_TOUT_CAP: begin
               if (sts.mode == mrrs_pkg::MODE_TICK) state_ff <= S_SLICE_RD;
               else state_ff <= S_RESULT;
            end
            S_SLICE_RD:  state_ff <= S_RESULT;
            S_RESULT:    if (sts.out_free) state_ff <= S_IDLE;
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd.res = res_ff;
      unique case (state_ff)
         S_CLEAR:     cmd.op = mrrs_pkg::OP_CLR;
         S_IDLE:      cmd.op = mrrs_pkg::OP_LOAD;
         S_DISPATCH:  cmd.op = mrrs_pkg::OP_IDX0;
         S_ALLOC_RD:  cmd.op = mrrs_pkg::OP_ALLOC_RD;
         S_ALLOC_CHK: cmd.op = mrrs_pkg::OP_ALLOC_CHK;
         S_SLOT_RD:   cmd.op = mrrs_pkg::OP_SLOT_RD;
         S_SLOT_CAP:  cmd.op = mrrs_pkg::OP_CAP_SLOT;
         S_BEF_RD:    cmd.op = mrrs_pkg::OP_RD_CUR;
         S_BEF_CAP:   cmd.op = mrrs_pkg::OP_CAP_BEFORE;
         S_SRCH_INIT: cmd.op = mrrs_pkg::OP_SRCH_INIT;
         S_SRCH_RD:   cmd.op = mrrs_pkg::OP_SRCH_RD;
         S_SRCH_CHK:  cmd.op = mrrs_pkg::OP_SRCH_CHK;
         S_REM_UPD:   cmd.op = mrrs_pkg::OP_REM_UPD;
         S_SH_RD:     cmd.op = mrrs_pkg::OP_SH_RD;
         S_SH_WR:     cmd.op = mrrs_pkg::OP_SH_WR;
         S_ADD:       cmd.op = mrrs_pkg::OP_ADD;
         S_FIND:      cmd.op = mrrs_pkg::OP_FIND;
         S_TICK:      cmd.op = mrrs_pkg::OP_TICK;
         S_TOUT_RD:   cmd.op = mrrs_pkg::OP_RD_CUR;
         S_TOUT_CAP:  cmd.op = mrrs_pkg::OP_CAP_TOUT;
         S_SLICE_RD:  cmd.op = mrrs_pkg::OP_RD_SLICE;
         S_RESULT:    cmd.op = sts.out_free ? mrrs_pkg::OP_RESULT : mrrs_pkg::OP_NONE;
         default:     cmd.op = mrrs_pkg::OP_NONE;
      endcase
   end
endmodule

// ----- hw/rtl/mrrs_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrrs_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  mrrs_pkg::cmd_type            cmd,
   output mrrs_pkg::sts_type            sts,
   input  logic [mrrs_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mrrs_pkg::RSP_W-1:0]   rsp_tdata
);
   localparam int TW = mrrs_pkg::TASK_W;
   localparam int LW = mrrs_pkg::LEVEL_W;
   localparam int CW = mrrs_pkg::CNT_W;
   localparam int SW = mrrs_pkg::SLICE_W;
   localparam int AW = mrrs_pkg::LIST_AW;
   localparam int NL = mrrs_pkg::NUM_LEVELS;

   // latched item
   mrrs_pkg::mode_type mode_ff;
   logic [TW-1:0]      tid_ff;
   logic [LW-1:0]      tlvl_ff;
   logic               keep_ff;
   logic [SW-1:0]      sreq_ff;

   logic [AW-1:0]      clr_ff;
   logic [CW-1:0]      i_ff;
   logic [1:0]         st_ff;
   logic [LW-1:0]      sl_ff;
   logic [TW-1:0]      before_ff;
   logic [TW-1:0]      tout_ff;
   logic [CW-1:0]      count_ff  [NL];
   logic [TW-1:0]      cursor_ff [NL];
   logic [LW-1:0]      active_ff;
   logic               recheck_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [TW-1:0]      rsp_task_ff;
   logic [SW-1:0]      rsp_slice_ff;
   logic               rsp_jump_ff;

   // memories
   logic          slot_re;
   logic [TW-1:0] slot_raddr;
   logic          st_we, lv_we, sc_we;
   logic [TW-1:0] st_waddr, lv_waddr, sc_waddr;
   logic [1:0]    st_wdata, st_rdata;
   logic [LW-1:0] lv_wdata, lv_rdata;
   logic [SW-1:0] sc_wdata, sc_rdata;
   logic          ls_we, ls_re;
   logic [AW-1:0] ls_waddr, ls_raddr;
   logic [TW-1:0] ls_wdata, ls_rdata;

   logic [LW-1:0] req_lvl, nl_lvl, top_lvl;
   logic [CW-1:0] cnt_sl, cnt_nl, cnt_act, n_rem, tick_adv;
   logic [TW-1:0] cur_act, cur_sl, cur_dec, cur_rem, cur_tick;

   mrrs_ram #(.WIDTH(2), .DEPTH(mrrs_pkg::NUM_TASKS)) u_status (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .re(slot_re), .raddr(slot_raddr), .rdata(st_rdata));
   mrrs_ram #(.WIDTH(LW), .DEPTH(mrrs_pkg::NUM_TASKS)) u_level (
      .clock(clock), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
      .re(slot_re), .raddr(slot_raddr), .rdata(lv_rdata));
   mrrs_ram #(.WIDTH(SW), .DEPTH(mrrs_pkg::NUM_TASKS)) u_slice (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
      .re(slot_re), .raddr(slot_raddr), .rdata(sc_rdata));
   mrrs_ram #(.WIDTH(TW), .DEPTH(mrrs_pkg::LIST_DEPTH)) u_list (
      .clock(clock), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
      .re(ls_re), .raddr(ls_raddr), .rdata(ls_rdata));

   // out-of-range levels saturate to the lowest level
   assign req_lvl = (req_tdata[10:8] > LW'(NL - 1)) ? LW'(NL - 1) : req_tdata[10:8];
   assign nl_lvl  = keep_ff ? sl_ff : tlvl_ff;
   assign cnt_sl  = count_ff[sl_ff];
   assign cnt_nl  = count_ff[nl_lvl];
   assign cnt_act = count_ff[active_ff];
   assign cur_act = cursor_ff[active_ff];
   assign cur_sl  = cursor_ff[sl_ff];

   always_comb begin
      top_lvl = LW'(NL - 1);
      for (int k = NL - 1; k >= 0; k--) begin
         if (count_ff[k] != '0) top_lvl = LW'(k);
      end
   end

   // removal at index i_ff: cursor steps back if past it, wraps if off the end
   assign n_rem    = cnt_sl - CW'(1);
   assign cur_dec  = (i_ff < {1'b0, cur_sl}) ? cur_sl - TW'(1) : cur_sl;
   assign cur_rem  = ({1'b0, cur_dec} >= n_rem) ? '0 : cur_dec;
   assign tick_adv = {1'b0, cur_act} + CW'(1);
   assign cur_tick = (tick_adv >= cnt_act) ? '0 : tick_adv[TW-1:0];

   always_comb begin
      slot_re    = 1'b0;
      slot_raddr = tid_ff;
      st_we = 1'b0; st_waddr = tid_ff; st_wdata = mrrs_pkg::SLOT_ALLOC;
      lv_we = 1'b0; lv_waddr = tid_ff; lv_wdata = nl_lvl;
      sc_we = 1'b0; sc_waddr = tid_ff; sc_wdata = sreq_ff;
      ls_we = 1'b0; ls_waddr = {sl_ff, i_ff[TW-1:0]}; ls_wdata = ls_rdata;
      ls_re = 1'b0; ls_raddr = {active_ff, cur_act};
      case (cmd.op)
         mrrs_pkg::OP_CLR: begin
            if (clr_ff < AW'(mrrs_pkg::NUM_TASKS)) begin
               st_we    = 1'b1;
               lv_we    = 1'b1;
               sc_we    = 1'b1;
               st_waddr = clr_ff[TW-1:0];
               lv_waddr = clr_ff[TW-1:0];
               sc_waddr = clr_ff[TW-1:0];
               st_wdata = (clr_ff < AW'(2)) ? mrrs_pkg::SLOT_RUN : mrrs_pkg::SLOT_FREE;
               lv_wdata = (clr_ff == AW'(1)) ? LW'(NL - 1) : '0;
               sc_wdata = (clr_ff == '0) ? SW'(2) : SW'(1);
            end
            ls_we    = 1'b1;
            ls_waddr = clr_ff;
            ls_wdata = (clr_ff == AW'((NL - 1) * mrrs_pkg::NUM_TASKS)) ? TW'(1) : '0;
         end
         mrrs_pkg::OP_ALLOC_RD: begin
            slot_re    = 1'b1;
            slot_raddr = i_ff[TW-1:0];
         end
         mrrs_pkg::OP_ALLOC_CHK: begin
            st_we    = (st_rdata == mrrs_pkg::SLOT_FREE);
            st_waddr = i_ff[TW-1:0];
            st_wdata = mrrs_pkg::SLOT_ALLOC;
         end
         mrrs_pkg::OP_SLOT_RD: begin
            slot_re = 1'b1;
            sc_we   = (mode_ff == mrrs_pkg::MODE_RUN) && (sreq_ff != '0);
         end
         mrrs_pkg::OP_SRCH_INIT: begin
            st_we    = 1'b1;
            st_wdata = mrrs_pkg::SLOT_ALLOC;
         end
         mrrs_pkg::OP_RD_CUR: ls_re = 1'b1;
         mrrs_pkg::OP_SRCH_RD: begin
            ls_re    = 1'b1;
            ls_raddr = {sl_ff, i_ff[TW-1:0]};
         end
         mrrs_pkg::OP_SH_RD: begin
            ls_re    = 1'b1;
            ls_raddr = {sl_ff, i_ff[TW-1:0] + TW'(1)};
         end
         mrrs_pkg::OP_SH_WR: ls_we = 1'b1;
         mrrs_pkg::OP_ADD: begin
            st_we    = 1'b1;
            st_wdata = mrrs_pkg::SLOT_RUN;
            lv_we    = 1'b1;
            ls_we    = (cnt_nl < CW'(mrrs_pkg::NUM_TASKS));
            ls_waddr = {nl_lvl, cnt_nl[TW-1:0]};
            ls_wdata = tid_ff;
         end
         mrrs_pkg::OP_RD_SLICE: begin
            slot_re    = 1'b1;
            slot_raddr = tout_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         active_ff    <= '0;
         recheck_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NL; k++) begin
            count_ff[k]  <= (k == 0 || k == NL - 1) ? CW'(1) : '0;
            cursor_ff[k] <= '0;
         end
      end else begin
         case (cmd.op)
            mrrs_pkg::OP_CLR:  clr_ff <= clr_ff + AW'(1);
            mrrs_pkg::OP_LOAD: begin
               mode_ff <= mrrs_pkg::mode_type'(req_tdata[1:0]);
               tid_ff  <= req_tdata[7:2];
               tlvl_ff <= req_lvl;
               keep_ff <= req_tdata[11];
               sreq_ff <= req_tdata[19:12];
            end
            mrrs_pkg::OP_IDX0, mrrs_pkg::OP_SRCH_INIT: i_ff <= '0;
            mrrs_pkg::OP_ALLOC_CHK: begin
               if (st_rdata != mrrs_pkg::SLOT_FREE) i_ff <= i_ff + CW'(1);
            end
            mrrs_pkg::OP_SLOT_RD: begin
               if (mode_ff == mrrs_pkg::MODE_RUN) recheck_ff <= 1'b1;
            end
            mrrs_pkg::OP_CAP_SLOT: begin
               st_ff <= st_rdata;
               sl_ff <= lv_rdata;
            end
            mrrs_pkg::OP_CAP_BEFORE: before_ff <= ls_rdata;
            mrrs_pkg::OP_SRCH_CHK: begin
               if (ls_rdata != tid_ff) i_ff <= i_ff + CW'(1);
            end
            mrrs_pkg::OP_REM_UPD: begin
               count_ff[sl_ff]  <= n_rem;
               cursor_ff[sl_ff] <= cur_rem;
            end
            mrrs_pkg::OP_SH_WR: i_ff <= i_ff + CW'(1);
            mrrs_pkg::OP_ADD: begin
               if (cnt_nl < CW'(mrrs_pkg::NUM_TASKS)) count_ff[nl_lvl] <= cnt_nl + CW'(1);
            end
            mrrs_pkg::OP_FIND: begin
               active_ff  <= top_lvl;
               recheck_ff <= 1'b0;
            end
            mrrs_pkg::OP_TICK: begin
               cursor_ff[active_ff] <= cur_tick;
               if (recheck_ff) begin
                  active_ff  <= top_lvl;
                  recheck_ff <= 1'b0;
               end
            end
            mrrs_pkg::OP_CAP_TOUT: tout_ff <= ls_rdata;
            default: ;
         endcase

         if (cmd.op == mrrs_pkg::OP_RESULT) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= cmd.res;
            if (mode_ff == mrrs_pkg::MODE_ALLOC) begin
               rsp_task_ff <= (cmd.res == mrrs_pkg::RES_OK) ? i_ff[TW-1:0] : '0;
            end else begin
               rsp_task_ff <= tout_ff;
            end
            rsp_slice_ff <= (mode_ff == mrrs_pkg::MODE_TICK) ? sc_rdata : '0;
            rsp_jump_ff  <= ((mode_ff == mrrs_pkg::MODE_TICK) ||
                             (mode_ff == mrrs_pkg::MODE_SLEEP && cmd.res == mrrs_pkg::RES_OK))
                            && (tout_ff != before_ff);
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clr_done   = (clr_ff == AW'(mrrs_pkg::LIST_DEPTH - 1));
   assign sts.mode       = mode_ff;
   assign sts.slot_free  = (st_rdata == mrrs_pkg::SLOT_FREE);
   assign sts.alloc_last = (i_ff == CW'(mrrs_pkg::NUM_TASKS - 1));
   assign sts.st_run     = (st_ff == mrrs_pkg::SLOT_RUN);
   assign sts.lvl_change = (sl_ff != nl_lvl);
   assign sts.match      = (ls_rdata == tid_ff);
   assign sts.idx_end    = (i_ff >= cnt_sl);
   assign sts.is_cur     = (tid_ff == before_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_jump_ff, rsp_slice_ff, rsp_task_ff, rsp_status_ff};

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff[active_ff] <= CW'(mrrs_pkg::NUM_TASKS))
   `ASSERT_ALWAYS(a_cursor_bound, clock, reset, (cursor_ff[active_ff] == '0) || ({1'b0, cursor_ff[active_ff]} < count_ff[active_ff]))
   `ASSERT_NEXT(a_find_clears, clock, reset, cmd.op == mrrs_pkg::OP_FIND, !recheck_ff)
endmodule

// ----- hw/rtl/multilevel_round_robin_scheduler_core.sv -----
`timescale 1ns / 1ps
// Multilevel round-robin task scheduler.
// req_ channel: one beat per command (allocate, run, sleep, timer tick).
// rsp_ channel: exactly one beat per command: status, task, slice, jump flag.
// Commands are handled one at a time; req_tready is high only when idle.
// Per command: allocate scans the slots for a free one; when a task leaves a
// level, run and sleep search that level's run list for it and shift the
// later entries down; tick advances the cursor of the active level.
// After reset the block loads the initial task table and run lists; no
// command is taken in that time.
// The result sits in an output register; a stalled rsp_tready holds it. One
// more command is still accepted, then waits in its result state until the
// register frees, so req_tready stays low behind a stalled receiver.
module multilevel_round_robin_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], task_id[7:2], target_level[10:8], keep_level[11],
   // slice_request[19:12], zero pad
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], task_out[7:2], slice_ticks[15:8], jump_needed[16], zero pad
   output logic [23:0] rsp_tdata
);
   mrrs_pkg::cmd_type cmd;
   mrrs_pkg::sts_type sts;

   mrrs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd));

   mrrs_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
endmodule
